// ----- design/qlnr_pkg.sv -----
`timescale 1ns / 1ps

package qlnr_pkg;

  // Field and datapath widths, and the queue depth.
  localparam int unsigned COEF_W      = 32;
  localparam int unsigned LIMIT_W     = 31;
  localparam int unsigned DISC_W      = 66;
  localparam int unsigned SQRT_W      = 33;
  localparam int unsigned MN_W        = 34;
  localparam int unsigned QDIV_W      = 64;
  localparam int unsigned RDIV_W      = 49;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd7;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_A_ZERO   = 2'd1,
    ST_COMPLEX  = 2'd2,
    ST_BOTH_NEG = 2'd3
  } status_e;

  // What the back end has to do with a transaction.
  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_BZERO = 2'd1,
    KIND_GEN   = 2'd2
  } kind_e;

  // Classified transaction held in the queue.
  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic               na;
    logic               nb;
    logic               nc;
    logic [COEF_W-1:0]  ma;
    logic [COEF_W-1:0]  mb;
    logic [COEF_W-1:0]  mc;
    logic [DISC_W-1:0]  disc;
  } item_t;

  // Side information carried through the square root.
  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic               na;
    logic               nb;
    logic               nc;
    logic [COEF_W-1:0]  ma;
    logic [COEF_W-1:0]  mb;
    logic [COEF_W-1:0]  mc;
  } post_t;

  // Side information carried through the first root divider; the second carries only the kind.
  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic               na;
    logic               nb;
    logic               nc;
    logic [COEF_W-1:0]  sroot;
  } mid_t;

endpackage

// ----- design/qlnr_front.sv -----
`timescale 1ns / 1ps

module qlnr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [qlnr_pkg::COEF_W-1:0] coef_a_i,
  input  logic [qlnr_pkg::COEF_W-1:0] coef_b_i,
  input  logic [qlnr_pkg::COEF_W-1:0] coef_c_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output qlnr_pkg::item_t            item_o
);
  import qlnr_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q;
  logic na1_q, nb1_q, nc1_q, na2_q, nb2_q, nc2_q;
  logic [COEF_W-1:0] ma1_q, mb1_q, mc1_q, ma2_q, mb2_q, mc2_q;
  logic [2*COEF_W-1:0] bb2_q, ac2_q;
  item_t item3_d, item3_q;
  logic [DISC_W-1:0] fac, bb66;

  // The whole front advances unless a finished transaction waits on a full queue.
  assign en           = !v3_q || push_ready_i;
  assign in_ready_o   = en;
  assign push_valid_o = v3_q;
  assign item_o       = item3_q;

  // Valid bits of the three front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage one splits coefficients into sign and magnitude; stage two forms products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      na1_q <= coef_a_i[COEF_W-1];
      nb1_q <= coef_b_i[COEF_W-1];
      nc1_q <= coef_c_i[COEF_W-1];
      ma1_q <= coef_a_i[COEF_W-1] ? (~coef_a_i + 1'b1) : coef_a_i;
      mb1_q <= coef_b_i[COEF_W-1] ? (~coef_b_i + 1'b1) : coef_b_i;
      mc1_q <= coef_c_i[COEF_W-1] ? (~coef_c_i + 1'b1) : coef_c_i;
      na2_q <= na1_q;
      nb2_q <= nb1_q;
      nc2_q <= nc1_q;
      ma2_q <= ma1_q;
      mb2_q <= mb1_q;
      mc2_q <= mc1_q;
      bb2_q <= mb1_q * mb1_q;
      ac2_q <= ma1_q * mc1_q;
      item3_q <= item3_d;
    end
  end

  // Stage three classifies the transaction and forms the discriminant.
  assign fac  = {ac2_q, 2'b00};
  assign bb66 = {2'b00, bb2_q};

  always_comb begin
    item3_d.kind   = KIND_GEN;
    item3_d.status = ST_OK;
    item3_d.na     = na2_q;
    item3_d.nb     = nb2_q;
    item3_d.nc     = nc2_q;
    item3_d.ma     = ma2_q;
    item3_d.mb     = mb2_q;
    item3_d.mc     = mc2_q;
    item3_d.disc   = '0;
    if (ma2_q == '0) begin
      item3_d.kind   = KIND_FIXED;
      item3_d.status = ST_A_ZERO;
    end else if (mc2_q == '0) begin
      item3_d.kind = KIND_FIXED;
    end else if (mb2_q == '0) begin
      if (na2_q == nc2_q) begin
        item3_d.kind   = KIND_FIXED;
        item3_d.status = ST_COMPLEX;
      end else begin
        item3_d.kind = KIND_BZERO;
      end
    end else if (na2_q != nc2_q) begin
      item3_d.disc = bb66 + fac;
    end else if (fac > bb66) begin
      item3_d.kind   = KIND_FIXED;
      item3_d.status = ST_COMPLEX;
    end else begin
      item3_d.disc = bb66 - fac;
    end
  end

endmodule

// ----- design/qlnr_fifo.sv -----
`timescale 1ns / 1ps

module qlnr_fifo #(
  parameter int unsigned DEPTH = qlnr_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  qlnr_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output qlnr_pkg::item_t pop_item_o
);
  import qlnr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/qlnr_div.sv -----
`timescale 1ns / 1ps

module qlnr_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] sb_o
);

  // One restoring quotient bit per stage, most significant bit first.
  logic          v_q  [NW+1];
  logic [NW-1:0] n_q  [NW+1];
  logic [NW-1:0] q_q  [NW+1];
  logic [DW-1:0] r_q  [NW+1];
  logic [DW-1:0] d_q  [NW+1];
  logic [SW-1:0] sb_q [NW+1];

  assign v_q[0]  = valid_i;
  assign n_q[0]  = num_i;
  assign q_q[0]  = '0;
  assign r_q[0]  = '0;
  assign d_q[0]  = den_i;
  assign sb_q[0] = sb_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] sh, diff;
    logic        ge;

    assign sh   = {r_q[s], n_q[s][NW-1]};
    assign diff = sh - {1'b0, d_q[s]};
    assign ge   = (sh >= {1'b0, d_q[s]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
        q_q[s+1]  <= {q_q[s][NW-2:0], ge};
        n_q[s+1]  <= {n_q[s][NW-2:0], 1'b0};
        d_q[s+1]  <= d_q[s];
        sb_q[s+1] <= sb_q[s];
      end
    end
  end

  assign valid_o = v_q[NW];
  assign quo_o   = q_q[NW];
  assign sb_o    = sb_q[NW];

endmodule

// ----- design/qlnr_sqrt.sv -----
`timescale 1ns / 1ps

module qlnr_sqrt #(
  parameter int unsigned RW = 33,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   sb_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   sb_o
);

  // One root bit per stage; each stage brings in two radicand bits.
  logic            v_q  [RW+1];
  logic [2*RW-1:0] x_q  [RW+1];
  logic [RW-1:0]   rt_q [RW+1];
  logic [RW+1:0]   r_q  [RW+1];
  logic [SW-1:0]   sb_q [RW+1];

  assign v_q[0]  = valid_i;
  assign x_q[0]  = rad_i;
  assign rt_q[0] = '0;
  assign r_q[0]  = '0;
  assign sb_q[0] = sb_i;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] sh, trial;
    logic          ge;

    // The partial remainder stays below 2^RW until the last stage.
    assign sh    = {r_q[s][RW-1:0], x_q[s][2*RW-1:2*RW-2]};
    assign trial = {rt_q[s], 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]  <= ge ? (sh - trial) : sh;
        rt_q[s+1] <= {rt_q[s][RW-2:0], ge};
        x_q[s+1]  <= {x_q[s][2*RW-3:0], 2'b00};
        sb_q[s+1] <= sb_q[s];
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = rt_q[RW];
  assign sb_o    = sb_q[RW];

endmodule

// ----- design/qlnr_back.sv -----
`timescale 1ns / 1ps

module qlnr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_o,
  input  qlnr_pkg::item_t              item_i,
  input  logic [qlnr_pkg::LIMIT_W-1:0] limit_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [qlnr_pkg::COEF_W-1:0]  root_o,
  output logic [1:0]                   status_o
);
  import qlnr_pkg::*;

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned POST_W = $bits(post_t);
  localparam int unsigned MID_W  = $bits(mid_t);
  localparam int unsigned KIND_W = $bits(kind_e);

  logic en;
  logic v0, vs, va_q, v1, v2;
  logic [QDIV_W-1:0] q0;
  logic [ITEM_W-1:0] sb0;
  item_t it0;
  logic [DISC_W-1:0] rad;
  post_t post_in, post;
  logic [POST_W-1:0] sbs;
  logic [SQRT_W-1:0] sroot;
  logic [MN_W-1:0] mn_q;
  logic [COEF_W-1:0] ma_q, mc_q;
  mid_t mid_q, mid1;
  logic [MID_W-1:0] sb1;
  logic [KIND_W-1:0] sb2;
  logic [RDIV_W-1:0] m1, m2;
  logic nn, neg1, neg2;
  logic [RDIV_W-1:0] m1f, m2f, lim_w, pick;
  logic [COEF_W-1:0] root_d, root_q;
  status_e status_d, status_q;
  logic out_valid_q;

  function automatic logic [COEF_W-1:0] sat32(input logic [RDIV_W-1:0] v);
    sat32 = (v[RDIV_W-1:COEF_W] != '0) ? '1 : v[COEF_W-1:0];
  endfunction

  // The back end moves as one pipeline whenever the output register can take data.
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && pop_valid_i;

  // Quotient |C| * 2^32 / |A| for the case of a zero linear coefficient.
  qlnr_div #(.NW(QDIV_W), .DW(COEF_W), .SW(ITEM_W)) u_div0 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pop_valid_i),
    .num_i({item_i.mc, {COEF_W{1'b0}}}), .den_i(item_i.ma), .sb_i(item_i),
    .valid_o(v0), .quo_o(q0), .sb_o(sb0)
  );

  assign it0 = item_t'(sb0);
  assign rad = (it0.kind == KIND_BZERO) ? {2'b00, q0} : it0.disc;

  always_comb begin
    post_in.kind   = it0.kind;
    post_in.status = it0.status;
    post_in.na     = it0.na;
    post_in.nb     = it0.nb;
    post_in.nc     = it0.nc;
    post_in.ma     = it0.ma;
    post_in.mb     = it0.mb;
    post_in.mc     = it0.mc;
  end

  // Shared square root: of the quotient or of the discriminant.
  qlnr_sqrt #(.RW(SQRT_W), .SW(POST_W)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0), .rad_i(rad), .sb_i(post_in),
    .valid_o(vs), .root_o(sroot), .sb_o(sbs)
  );

  assign post = post_t'(sbs);

  // |N| = |B| + S.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mn_q         <= MN_W'(post.mb) + MN_W'(sroot);
      ma_q         <= post.ma;
      mc_q         <= post.mc;
      mid_q.kind   <= post.kind;
      mid_q.status <= post.status;
      mid_q.na     <= post.na;
      mid_q.nb     <= post.nb;
      mid_q.nc     <= post.nc;
      mid_q.sroot  <= sroot[COEF_W-1:0];
    end
  end

  // The two root magnitudes, computed side by side.
  qlnr_div #(.NW(RDIV_W), .DW(COEF_W), .SW(MID_W)) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va_q),
    .num_i({mn_q[RDIV_W-16:0], 15'b0}), .den_i(ma_q), .sb_i(mid_q),
    .valid_o(v1), .quo_o(m1), .sb_o(sb1)
  );

  qlnr_div #(.NW(RDIV_W), .DW(MN_W), .SW(KIND_W)) u_div2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va_q),
    .num_i({mc_q, 17'b0}), .den_i(mn_q), .sb_i(mid_q.kind),
    .valid_o(v2), .quo_o(m2), .sb_o(sb2)
  );

  assign mid1  = mid_t'(sb1);
  assign lim_w = RDIV_W'(limit_i);

  // Root selection with the near-zero rule and saturation.
  always_comb begin
    nn       = !mid1.nb;
    neg1     = (nn != mid1.na) && (m1 != '0);
    neg2     = (mid1.nc != nn) && (m2 != '0);
    m1f      = m1;
    m2f      = m2;
    pick     = '0;
    root_d   = '0;
    status_d = mid1.status;
    if (neg1 && neg2) begin
      if (m1 < lim_w) begin
        m1f  = '0;
        neg1 = 1'b0;
      end else if (m2 < lim_w) begin
        m2f  = '0;
        neg2 = 1'b0;
      end
    end
    unique case (kind_e'(sb2))
      KIND_BZERO: begin
        root_d = mid1.sroot;
      end
      KIND_GEN: begin
        if (neg1 && neg2) begin
          status_d = ST_BOTH_NEG;
        end else begin
          if (neg1) begin
            pick = m2f;
          end else if (neg2) begin
            pick = m1f;
          end else begin
            pick = (m1f < m2f) ? m1f : m2f;
          end
          root_d = sat32(pick);
        end
      end
      default: begin
        root_d = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_q   <= root_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni) v1 == v2)
    else $error("root dividers out of step");
  a_kind_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1 |-> (sb2 == mid1.kind))
    else $error("divider side information disagrees");
  a_err_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (root_o == '0))
    else $error("nonzero root with error status");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> pop_valid_i)
    else $error("pop from empty queue");
`endif

endmodule

// ----- design/quadratic_least_nonnegative_root_core.sv -----
`timescale 1ns / 1ps

// Channel  | Valid         | Ready         | Data
// ---------+---------------+---------------+-------------------------------
// input    | in_valid_i    | in_ready_o    | coef_a_i, coef_b_i, coef_c_i
// output   | out_valid_o   | out_ready_i   | root_o, status_o
// config   | cfg_we_i      | (none)        | cfg_wdata_i
//
// One transaction is accepted per cycle while in_ready_o is high; the path runs through
// three front stages and the queue, then the bit-per-stage quotient pipeline (64 stages),
// square root (33 stages), root dividers (49 stages) and the output register.
// The front and the back stall separately; the queue absorbs a stalled output.
// Reset clears all valid bits and sets the near-zero limit to 7.

module quadratic_least_nonnegative_root_core #(
  parameter int unsigned QUEUE_DEPTH = qlnr_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [qlnr_pkg::COEF_W-1:0]  coef_a_i,
  input  logic [qlnr_pkg::COEF_W-1:0]  coef_b_i,
  input  logic [qlnr_pkg::COEF_W-1:0]  coef_c_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [qlnr_pkg::COEF_W-1:0]  root_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_we_i,
  input  logic [qlnr_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import qlnr_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic  push_valid, push_ready, pop_valid, pop;
  item_t push_item, pop_item;

  // Near-zero limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  qlnr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .push_valid_o(push_valid), .push_ready_i(push_ready), .item_o(push_item)
  );

  qlnr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_valid_i(push_valid), .push_ready_o(push_ready),
    .push_item_i(push_item), .pop_valid_o(pop_valid), .pop_ready_i(pop),
    .pop_item_o(pop_item)
  );

  qlnr_back u_back (
    .clk_i, .rst_ni, .pop_valid_i(pop_valid), .pop_o(pop), .item_i(pop_item),
    .limit_i(limit_q), .out_valid_o, .out_ready_i, .root_o, .status_o
  );

endmodule
